>>> hw/rtl/sstf_disk_scheduler_assert.svh
// Assertion macros shared by the disk scheduler modules.
`ifndef SSTF_DISK_SCHEDULER_ASSERT_SVH
`define SSTF_DISK_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSTF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sstf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSTF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sstf assertion failed");

`endif

>>> hw/rtl/sstf_pkg.sv
// Shared types and constants of the disk scheduler.
package sstf_pkg;

   localparam int CYL_W = 8;
   localparam int TOT_W = 14;

   // Configuration register indexes.
   localparam logic REG_START_HEAD   = 1'b0;
   localparam logic REG_MAX_CYLINDER = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [CYL_W-1:0] START_HEAD_RESET   = 8'd0;
   localparam logic [CYL_W-1:0] MAX_CYLINDER_RESET = 8'd199;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // store an incoming request
      logic launch;   // begin a batch at the start head
      logic rd_en;    // read one stored entry for the scan
      logic emit;     // serve the best entry and send a result
      logic rescan;   // forget the best entry before a new scan
      logic clear;    // close the batch
   } sstf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;    // no request is stored
      logic final_hit; // the entry being served is the last of the batch
   } sstf_status_type;

endpackage

>>> hw/rtl/sstf_disk_scheduler.sv
// Top level of the shortest-seek-time-first disk scheduler.
//
//   Channel  Ports                              Transfer
//   request  start, busy, req_*                 start high while busy low
//   result   rsp_valid, rsp_*                   rsp_valid high, one cycle
//   config   csr_wr_en, csr_index, csr_wdata    csr_wr_en high
//
// A request without last is accepted while idle. A last request adds a launch state, then
// each served request takes a scan that reads all N stored requests of the batch on the
// single read port, a drain state for the last read, and a serve state.
// Busy stays high from the launch until the final result is served.
// Reset is synchronous; the store needs no clearing; fill count and state are reset.
// Results cannot be stalled; each one is shown for exactly one cycle.
module sstf_disk_scheduler import sstf_pkg::*; #(
   parameter int MAX_REQUESTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [CYL_W-1:0] req_cylinder,
   input  logic             req_last,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [CYL_W-1:0] csr_wdata,
   output logic             rsp_valid,
   output logic [CYL_W-1:0] rsp_served_cylinder,
   output logic [CYL_W-1:0] rsp_seek_distance,
   output logic [TOT_W-1:0] rsp_total_movement,
   output logic             rsp_dropped_flag,
   output logic             rsp_final_res
);

   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

   sstf_cmd_type    cmd;
   sstf_status_type status;
   logic [IDX_W-1:0] rd_addr;
   logic [CNT_W-1:0] count;

   sstf_controller #(
      .MAX_REQUESTS (MAX_REQUESTS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_last),
      .busy     (busy),
      .cmd      (cmd),
      .rd_addr  (rd_addr),
      .status   (status),
      .count    (count)
   );

   sstf_datapath #(
      .MAX_REQUESTS (MAX_REQUESTS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .rd_addr             (rd_addr),
      .status              (status),
      .count               (count),
      .req_cylinder        (req_cylinder),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_served_cylinder (rsp_served_cylinder),
      .rsp_seek_distance   (rsp_seek_distance),
      .rsp_total_movement  (rsp_total_movement),
      .rsp_dropped_flag    (rsp_dropped_flag),
      .rsp_final_res       (rsp_final_res)
   );

endmodule

>>> hw/rtl/sstf_datapath.sv
// Datapath of the disk scheduler: request store, nearest-entry scan and results.
`include "sstf_disk_scheduler_assert.svh"

module sstf_datapath import sstf_pkg::*; #(
   parameter int MAX_REQUESTS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sstf_cmd_type                         cmd,
   input  logic [((MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1)-1:0] rd_addr,
   output sstf_status_type                      status,
   output logic [$clog2(MAX_REQUESTS + 1)-1:0]  count,
   input  logic [CYL_W-1:0]                     req_cylinder,
   input  logic                                 csr_wr_en,
   input  logic                                 csr_index,
   input  logic [CYL_W-1:0]                     csr_wdata,
   output logic                                 rsp_valid,
   output logic [CYL_W-1:0]                     rsp_served_cylinder,
   output logic [CYL_W-1:0]                     rsp_seek_distance,
   output logic [TOT_W-1:0]                     rsp_total_movement,
   output logic                                 rsp_dropped_flag,
   output logic                                 rsp_final_res
);

   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

   // Each entry holds a served mark above the cylinder.
   logic [CYL_W:0]     mem [MAX_REQUESTS];
   logic [CYL_W:0]     rd_data_ff;
   logic               rd_valid_ff;
   logic [IDX_W-1:0]   rd_idx_ff;

   logic [CYL_W-1:0]   start_head_ff, start_head_in;
   logic [CYL_W-1:0]   max_cyl_ff, max_cyl_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   served_ff, served_in;
   logic               overflow_ff, overflow_in;
   logic [CYL_W-1:0]   head_ff, head_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [CYL_W-1:0]   best_cyl_ff, best_cyl_in;
   logic [CYL_W-1:0]   best_dist_ff, best_dist_in;
   logic               rsp_valid_ff;
   logic [CYL_W-1:0]   rsp_cyl_ff, rsp_dist_ff;
   logic [TOT_W-1:0]   rsp_total_ff;
   logic               rsp_drop_ff, rsp_final_ff;

   logic               store_req;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [CYL_W:0]     mem_wdata;
   logic [CYL_W-1:0]   cand_cyl;
   logic [CYL_W-1:0]   cand_dist;
   logic               cand_better;
   logic               final_hit;
   logic [TOT_W-1:0]   total_sum;

   // Candidate distance from the current head and the better-than test.
   always_comb begin
      cand_cyl    = rd_data_ff[CYL_W-1:0];
      cand_dist   = (cand_cyl >= head_ff) ? (cand_cyl - head_ff) : (head_ff - cand_cyl);
      cand_better = rd_valid_ff && !rd_data_ff[CYL_W] &&
                    (!found_ff || (cand_dist < best_dist_ff));
   end

   assign final_hit = (served_ff == (count_ff - CNT_W'(1)));
   assign total_sum = total_ff + TOT_W'(best_dist_ff);
   assign store_req = cmd.accept && (req_cylinder <= max_cyl_ff) &&
                      (count_ff < CNT_W'(MAX_REQUESTS));

   // Store write port: new requests during collection, served marks on emit.
   always_comb begin
      mem_we    = store_req || cmd.emit;
      mem_waddr = cmd.emit ? best_idx_ff : count_ff[IDX_W-1:0];
      mem_wdata = cmd.emit ? {1'b1, best_cyl_ff} : {1'b0, req_cylinder};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
      rd_idx_ff  <= rd_addr;
   end

   // Next values of the batch state and configuration.
   always_comb begin
      start_head_in = start_head_ff;
      max_cyl_in    = max_cyl_ff;
      count_in      = count_ff;
      served_in     = served_ff;
      overflow_in   = overflow_ff;
      head_in       = head_ff;
      total_in      = total_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_cyl_in   = best_cyl_ff;
      best_dist_in  = best_dist_ff;

      if (csr_wr_en) begin
         case (csr_index)
            REG_START_HEAD:   start_head_in = csr_wdata;
            REG_MAX_CYLINDER: max_cyl_in    = csr_wdata;
            default:          ;
         endcase
      end

      if (store_req) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.accept && (req_cylinder <= max_cyl_ff)) begin
         overflow_in = 1'b1;
      end

      if (cmd.launch) begin
         head_in   = start_head_ff;
         served_in = '0;
         found_in  = 1'b0;
      end

      if (cand_better) begin
         found_in     = 1'b1;
         best_idx_in  = rd_idx_ff;
         best_cyl_in  = cand_cyl;
         best_dist_in = cand_dist;
      end

      if (cmd.emit) begin
         head_in   = best_cyl_ff;
         total_in  = total_sum;
         served_in = served_ff + CNT_W'(1);
      end

      if (cmd.rescan) begin
         found_in = 1'b0;
      end

      if (cmd.clear) begin
         count_in    = '0;
         served_in   = '0;
         overflow_in = 1'b0;
         total_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_head_ff <= START_HEAD_RESET;
         max_cyl_ff    <= MAX_CYLINDER_RESET;
         count_ff      <= '0;
         served_ff     <= '0;
         overflow_ff   <= 1'b0;
         head_ff       <= '0;
         total_ff      <= '0;
         found_ff      <= 1'b0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         start_head_ff <= start_head_in;
         max_cyl_ff    <= max_cyl_in;
         count_ff      <= count_in;
         served_ff     <= served_in;
         overflow_ff   <= overflow_in;
         head_ff       <= head_in;
         total_ff      <= total_in;
         found_ff      <= found_in;
         rd_valid_ff   <= cmd.rd_en;
         rsp_valid_ff  <= cmd.emit;
      end
   end

   // Best-entry and result payload registers.
   always_ff @(posedge clock) begin
      best_idx_ff  <= best_idx_in;
      best_cyl_ff  <= best_cyl_in;
      best_dist_ff <= best_dist_in;
      if (cmd.emit) begin
         rsp_cyl_ff   <= best_cyl_ff;
         rsp_dist_ff  <= best_dist_ff;
         rsp_total_ff <= total_sum;
         rsp_drop_ff  <= overflow_ff;
         rsp_final_ff <= final_hit;
      end
   end

   assign status.empty     = (count_ff == '0);
   assign status.final_hit = final_hit;
   assign count            = count_ff;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_served_cylinder = rsp_cyl_ff;
   assign rsp_seek_distance   = rsp_dist_ff;
   assign rsp_total_movement  = rsp_total_ff;
   assign rsp_dropped_flag    = rsp_drop_ff;
   assign rsp_final_res       = rsp_final_ff;

   // A served entry must have been found by the scan that preceded it.
   `SSTF_ASSERT_SAME(a_emit_found, clock, reset, cmd.emit, found_ff)
   // The fill count never passes the store depth.
   `SSTF_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_REQUESTS))
   // After the last result the batch is empty again.
   `SSTF_ASSERT_NEXT(a_final_clears, clock, reset, cmd.emit && final_hit,
                     count_ff == '0 && total_ff == '0)

endmodule

>>> hw/rtl/sstf_controller.sv
// Controller of the disk scheduler: batch sequencing and scan addressing.
`include "sstf_disk_scheduler_assert.svh"

module sstf_controller import sstf_pkg::*; #(
   parameter int MAX_REQUESTS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 req_last,
   output logic                                 busy,
   output sstf_cmd_type                         cmd,
   output logic [((MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1)-1:0] rd_addr,
   input  sstf_status_type                      status,
   input  logic [$clog2(MAX_REQUESTS + 1)-1:0]  count
);

   localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             scan_end;

   assign scan_end = (CNT_W'(idx_ff) == (count - CNT_W'(1)));

   // Command decode and next state.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (req_last) begin
                  state_in = ST_LAUNCH;
               end
            end
         end
         ST_LAUNCH: begin
            if (status.empty) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd.launch = 1'b1;
               idx_in     = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (scan_end) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.final_hit) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd.rescan = 1'b1;
               idx_in     = '0;
               state_in   = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign busy    = (state_ff != ST_IDLE);
   assign rd_addr = idx_ff;

   // The scan never addresses an entry beyond the fill count.
   `SSTF_ASSERT_SAME(a_scan_in_range, clock, reset, state_ff == ST_SCAN,
                     CNT_W'(idx_ff) < count)
   // A launch, made only for a non-empty batch, starts the scan at entry zero.
   `SSTF_ASSERT_NEXT(a_launch_scan, clock, reset, cmd.launch,
                     state_ff == ST_SCAN && idx_ff == '0)

endmodule
